// File: src/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/svpwm_pkg.sv
// Package of the space-vector PWM duty unit: word types, codes and the shaping table.
// Depends on nothing; used by the unit and its checker.
`default_nettype none

package svpwm_pkg;

  localparam int unsigned PhaseW = 11;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned OffW   = 9;
  localparam int unsigned ProdW  = 16;
  localparam int unsigned Latency = 4;

  localparam logic [1:0] SecFirst  = 2'd0;
  localparam logic [1:0] SecSecond = 2'd1;
  localparam logic [1:0] SecThird  = 2'd2;
  localparam logic [1:0] SecBad    = 2'd3;

  localparam logic [1:0] RegLow  = 2'd0;
  localparam logic [1:0] RegHigh = 2'd3;

  typedef struct packed {
    logic [PhaseW-1:0] phase_position;
    logic [DutyW-1:0]  amplitude;
  } cmd_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_first;
    logic [DutyW-1:0] duty_second;
    logic [DutyW-1:0] duty_third;
  } res_t;

  localparam logic [7:0] ShapeRom [256] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
    8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253,
    8'd253, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252,
    8'd252, 8'd252, 8'd251, 8'd251, 8'd251, 8'd251, 8'd251, 8'd251,
    8'd251, 8'd251, 8'd250, 8'd250, 8'd250, 8'd250, 8'd250, 8'd250,
    8'd250, 8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd248,
    8'd248, 8'd248, 8'd248, 8'd248, 8'd248, 8'd247, 8'd247, 8'd247,
    8'd247, 8'd247, 8'd246, 8'd246, 8'd246, 8'd246, 8'd246, 8'd245,
    8'd245, 8'd245, 8'd245, 8'd245, 8'd244, 8'd244, 8'd244, 8'd244,
    8'd244, 8'd243, 8'd243, 8'd243, 8'd243, 8'd243, 8'd242, 8'd242,
    8'd242, 8'd242, 8'd241, 8'd241, 8'd241, 8'd241, 8'd240, 8'd240,
    8'd240, 8'd240, 8'd239, 8'd239, 8'd239, 8'd239, 8'd238, 8'd238,
    8'd238, 8'd237, 8'd236, 8'd236, 8'd235, 8'd234, 8'd233, 8'd232,
    8'd232, 8'd231, 8'd230, 8'd229, 8'd228, 8'd228, 8'd227, 8'd226,
    8'd225, 8'd224, 8'd224, 8'd223, 8'd222, 8'd221, 8'd220, 8'd219,
    8'd219, 8'd218, 8'd217, 8'd216, 8'd215, 8'd215, 8'd214, 8'd213,
    8'd212, 8'd211, 8'd210, 8'd210, 8'd209, 8'd208, 8'd207, 8'd206,
    8'd205, 8'd204, 8'd204, 8'd203, 8'd202, 8'd201, 8'd200, 8'd199,
    8'd198, 8'd198, 8'd197, 8'd196, 8'd195, 8'd194, 8'd193, 8'd192,
    8'd192, 8'd191, 8'd190, 8'd189, 8'd188, 8'd187, 8'd186, 8'd186,
    8'd185, 8'd184, 8'd183, 8'd182, 8'd181, 8'd180, 8'd179, 8'd179,
    8'd178, 8'd177, 8'd176, 8'd175, 8'd174, 8'd173, 8'd172, 8'd171,
    8'd171, 8'd170, 8'd169, 8'd168, 8'd167, 8'd166, 8'd165, 8'd164,
    8'd163, 8'd163, 8'd162, 8'd161, 8'd160, 8'd159, 8'd158, 8'd157,
    8'd156, 8'd155, 8'd155, 8'd154, 8'd153, 8'd152, 8'd151, 8'd150,
    8'd149, 8'd148, 8'd147, 8'd146, 8'd146, 8'd145, 8'd144, 8'd143,
    8'd142, 8'd141, 8'd140, 8'd139, 8'd138, 8'd137, 8'd137, 8'd136,
    8'd135, 8'd134, 8'd133, 8'd132, 8'd131, 8'd130, 8'd129, 8'd128
  };

endpackage

`default_nettype wire

// File: src/svpwm_duty_from_phase_unit.sv
// Space-vector PWM duty unit: three compare values from a phase and an amplitude.
// Depends on svpwm_pkg for the word types and the shaping table.
//
// Usage: drive a command word on cmd_i and raise start_i for one cycle per word.
// A word is taken at every rising edge where start_i is high and busy_o is low.
// busy_o stays low: a new word may be issued in every cycle, one word per cycle.
// Each command gives one result word on res_o, marked by res_valid_o for exactly
// one cycle, once the command has passed the four register stages named below.
// The four register stages are: input and section decode, shaping table read,
// complement and amplitude multiply, divide by full scale and channel rotation.
// The receiver cannot stall; results leave in command order.
// Reset clears all valid bits, so no result appears that was not commanded.
`default_nettype none

module svpwm_duty_from_phase_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  svpwm_pkg::cmd_t      cmd_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output svpwm_pkg::res_t      res_o
);
  import svpwm_pkg::*;

  logic            accept;
  logic [1:0]      sec_d;
  logic [OffW-1:0] off;
  logic [1:0]      region;
  logic [IdxW-1:0] idx_a_d, idx_b_d;
  logic [OffW-1:0] diff_b;
  logic            inv_a_d, inv_b_d, c_from_b_d;

  logic            v1_q, v2_q, v3_q, vo_q;
  logic [1:0]      sec1_q, sec2_q, sec3_q;
  logic [IdxW-1:0] idx_a_q, idx_b_q;
  logic            inv_a1_q, inv_b1_q, cb1_q;
  logic            inv_a2_q, inv_b2_q, cb2_q;
  logic [DutyW-1:0] amp1_q, amp2_q;
  logic [DutyW-1:0] wa_q, wb_q;
  logic [DutyW-1:0] a_val, b_val, c_val;
  logic [ProdW-1:0] pa_q, pb_q, pc_q;
  logic [DutyW-1:0] qa, qb, qc;
  res_t             res_d, res_q;

  function automatic logic [DutyW-1:0] div_fs(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, p} + {9'd0, p[ProdW-1:8]} + 17'd1;
    return s[ProdW:8] == 9'd0 ? 8'd0 : s[15:8];
  endfunction

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    sec_d = cmd_i.phase_position[10:9];
    off   = cmd_i.phase_position[8:0];
    if (sec_d == SecBad) begin
      sec_d = SecFirst;
      off   = '0;
    end
    region = off[8:7];
    diff_b = 9'd383 - off;
    case (region)
      RegLow: begin
        idx_a_d    = {1'b0, ~off[6:0]};
        idx_b_d    = {1'b1, off[6:0]};
        inv_a_d    = 1'b0;
        inv_b_d    = 1'b1;
        c_from_b_d = 1'b0;
      end
      RegHigh: begin
        idx_a_d    = {1'b1, ~off[6:0]};
        idx_b_d    = {1'b0, off[6:0]};
        inv_a_d    = 1'b1;
        inv_b_d    = 1'b0;
        c_from_b_d = 1'b1;
      end
      default: begin
        idx_a_d    = off[7:0] - 8'd128;
        idx_b_d    = diff_b[7:0];
        inv_a_d    = 1'b0;
        inv_b_d    = 1'b0;
        c_from_b_d = off[8];
      end
    endcase
  end

  always_comb begin
    a_val = inv_a2_q ? ~wa_q : wa_q;
    b_val = inv_b2_q ? ~wb_q : wb_q;
    c_val = cb2_q ? ~b_val : ~a_val;
  end

  always_comb begin
    qa = div_fs(pa_q);
    qb = div_fs(pb_q);
    qc = div_fs(pc_q);
    case (sec3_q)
      SecSecond: res_d = '{duty_first: qc, duty_second: qa, duty_third: qb};
      SecThird:  res_d = '{duty_first: qb, duty_second: qc, duty_third: qa};
      default:   res_d = '{duty_first: qa, duty_second: qb, duty_third: qc};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sec1_q   <= sec_d;
    idx_a_q  <= idx_a_d;
    idx_b_q  <= idx_b_d;
    inv_a1_q <= inv_a_d;
    inv_b1_q <= inv_b_d;
    cb1_q    <= c_from_b_d;
    amp1_q   <= cmd_i.amplitude;

    sec2_q   <= sec1_q;
    wa_q     <= ShapeRom[idx_a_q];
    wb_q     <= ShapeRom[idx_b_q];
    inv_a2_q <= inv_a1_q;
    inv_b2_q <= inv_b1_q;
    cb2_q    <= cb1_q;
    amp2_q   <= amp1_q;

    sec3_q   <= sec2_q;
    pa_q     <= ProdW'(a_val) * ProdW'(amp2_q);
    pb_q     <= ProdW'(b_val) * ProdW'(amp2_q);
    pc_q     <= ProdW'(c_val) * ProdW'(amp2_q);

    res_q    <= res_d;
  end

  assign res_valid_o = vo_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// File: src/svpwm_chk.sv
// Port-level checker for the space-vector PWM duty unit, bound to its top level.
// Depends on svpwm_pkg and on the assertion macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module svpwm_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input svpwm_pkg::cmd_t cmd_i,
  input wire logic       busy_o,
  input wire logic       res_valid_o,
  input svpwm_pkg::res_t res_o
);
  import svpwm_pkg::*;

  `ASSERT_NEVER(never_busy, clk_i, rst_ni, busy_o, "unit signaled busy")
  `ASSERT_PROP(cmd_gives_res, clk_i, rst_ni, (start_i && !busy_o) |-> ##4 res_valid_o, "result missing after command")
  `ASSERT_PROP(res_has_cmd, clk_i, rst_ni, res_valid_o |-> $past(start_i && !busy_o, 4), "result without command")
  `ASSERT_PROP(zero_amp_zero_duty, clk_i, rst_ni, (start_i && !busy_o && cmd_i.amplitude == 8'd0) |-> ##4 (res_o == '0), "zero amplitude gave nonzero duty")

endmodule

bind svpwm_duty_from_phase_unit svpwm_chk u_chk (.*);

`default_nettype wire
